// File: rtl/core/qdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, constants and decode function for the quadrature detent
// decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

    localparam int TIME_W   = 32;
    localparam int POS_W    = 9;
    localparam int CNT_W    = 8;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_COUNTS_PER_DETENT  = 3'd0;
    localparam cfg_index_t REG_ACCEL_ENABLE       = 3'd1;
    localparam cfg_index_t REG_ACCEL_RATE         = 3'd2;
    localparam cfg_index_t REG_ACCEL_THRESHOLD_MS = 3'd3;
    localparam cfg_index_t REG_IDLE_TIMEOUT_MS    = 3'd4;
    localparam cfg_index_t REG_DECODER_ENABLE     = 3'd5;

    localparam logic [CNT_W-1:0] RST_COUNTS_PER_DETENT  = 8'd4;
    localparam logic             RST_ACCEL_ENABLE       = 1'b0;
    localparam logic [CNT_W-1:0] RST_ACCEL_RATE         = 8'd2;
    localparam logic [MS_W-1:0]  RST_ACCEL_THRESHOLD_MS = 16'd50;
    localparam logic [MS_W-1:0]  RST_IDLE_TIMEOUT_MS    = 16'd500;
    localparam logic             RST_DECODER_ENABLE     = 1'b1;

    // {prev A, prev B, cur A, cur B}
    localparam logic [3:0] CW_0  = 4'b0001;
    localparam logic [3:0] CW_1  = 4'b0111;
    localparam logic [3:0] CW_2  = 4'b1110;
    localparam logic [3:0] CW_3  = 4'b1000;
    localparam logic [3:0] CCW_0 = 4'b0010;
    localparam logic [3:0] CCW_1 = 4'b1011;
    localparam logic [3:0] CCW_2 = 4'b1101;
    localparam logic [3:0] CCW_3 = 4'b0100;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [CNT_W-1:0] counts_per_detent;
        logic             accel_enable;
        logic [CNT_W-1:0] accel_rate;
        logic [MS_W-1:0]  accel_threshold_ms;
        logic [MS_W-1:0]  idle_timeout_ms;
        logic             decoder_enable;
        logic             clear_pos;
    } cfg_t;

    function automatic dir_t decode_dir(input logic [3:0] code);
        dir_t d;
        unique case (code) inside
            CW_0, CW_1, CW_2, CW_3:     d = DIR_CW;
            CCW_0, CCW_1, CCW_2, CCW_3: d = DIR_CCW;
            default:                    d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/qdd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdd_if
// Valid/ready channels for pin samples, detent results and register writes.
// ----------------------------------------------------------------------------
interface qdd_sample_if;
    logic                        valid;
    logic                        ready;
    logic                        pin_a;
    logic                        pin_b;
    logic [qdd_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output pin_a, output pin_b, output now_ms, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input now_ms, output ready);
endinterface

interface qdd_result_if;
    logic                              valid;
    logic                              ready;
    logic                              detent_event;
    logic signed [qdd_pkg::POS_W-1:0]  detent_step;
    logic signed [qdd_pkg::POS_W-1:0]  sub_position;

    modport source (output valid, output detent_event, output detent_step,
                    output sub_position, input ready);
    modport sink   (input valid, input detent_event, input detent_step,
                    input sub_position, output ready);
endinterface

interface qdd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [qdd_pkg::CFG_IDX_W-1:0]   index;
    logic [qdd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/qdd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdd_cfg_regs
// Configuration register bank; flags a position clear on disable.
// ----------------------------------------------------------------------------
module qdd_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    qdd_cfg_if.sink       cfg,
    output qdd_pkg::cfg_t regs
);

    logic [qdd_pkg::CNT_W-1:0] cpd_reg;
    logic                      accel_en_reg;
    logic [qdd_pkg::CNT_W-1:0] rate_reg;
    logic [qdd_pkg::MS_W-1:0]  thr_reg;
    logic [qdd_pkg::MS_W-1:0]  timeout_reg;
    logic                      dec_en_reg;
    logic                      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpd_reg      <= qdd_pkg::RST_COUNTS_PER_DETENT;
            accel_en_reg <= qdd_pkg::RST_ACCEL_ENABLE;
            rate_reg     <= qdd_pkg::RST_ACCEL_RATE;
            thr_reg      <= qdd_pkg::RST_ACCEL_THRESHOLD_MS;
            timeout_reg  <= qdd_pkg::RST_IDLE_TIMEOUT_MS;
            dec_en_reg   <= qdd_pkg::RST_DECODER_ENABLE;
        end
        else if (wr)
        begin
            unique case (cfg.index)
                qdd_pkg::REG_COUNTS_PER_DETENT:  cpd_reg      <= cfg.data[qdd_pkg::CNT_W-1:0];
                qdd_pkg::REG_ACCEL_ENABLE:       accel_en_reg <= cfg.data[0];
                qdd_pkg::REG_ACCEL_RATE:         rate_reg     <= cfg.data[qdd_pkg::CNT_W-1:0];
                qdd_pkg::REG_ACCEL_THRESHOLD_MS: thr_reg      <= cfg.data[qdd_pkg::MS_W-1:0];
                qdd_pkg::REG_IDLE_TIMEOUT_MS:    timeout_reg  <= cfg.data[qdd_pkg::MS_W-1:0];
                qdd_pkg::REG_DECODER_ENABLE:     dec_en_reg   <= cfg.data[0];
                default:                         ;
            endcase
        end
    end

    always_comb
    begin
        regs.counts_per_detent  = cpd_reg;
        regs.accel_enable       = accel_en_reg;
        regs.accel_rate         = rate_reg;
        regs.accel_threshold_ms = thr_reg;
        regs.idle_timeout_ms    = timeout_reg;
        regs.decoder_enable     = dec_en_reg;
        regs.clear_pos          = wr && (cfg.index == qdd_pkg::REG_DECODER_ENABLE)
                                  && !cfg.data[0];
    end

endmodule
`default_nettype wire

// File: rtl/core/qdd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdd_datapath
// Input register, quadrature decode and detent state, result register.
// ----------------------------------------------------------------------------
module qdd_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire qdd_pkg::cfg_t regs,
    qdd_sample_if.sink         sample,
    qdd_result_if.source       result
);

    localparam int TW = qdd_pkg::TIME_W;
    localparam int PW = qdd_pkg::POS_W;

    // input stage
    logic          in_valid_reg;
    logic          in_a_reg;
    logic          in_b_reg;
    logic [TW-1:0] in_now_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 out_event_reg;
    logic signed [PW-1:0] out_step_reg;
    logic signed [PW-1:0] out_pos_reg;

    // detent state
    logic                 primed_reg;
    logic [1:0]           prev_pins_reg;
    logic signed [PW-1:0] partial_reg;
    logic [TW-1:0]        last_move_reg;
    logic [TW-1:0]        last_det_reg;

    logic                 primed_next;
    logic [1:0]           prev_pins_next;
    logic signed [PW-1:0] partial_next;
    logic [TW-1:0]        last_move_next;
    logic [TW-1:0]        last_det_next;
    logic                 event_next;
    logic signed [PW-1:0] step_next;

    logic                 out_free;
    logic                 fire;
    logic [1:0]           pins;
    qdd_pkg::dir_t        dir;
    logic signed [PW-1:0] sum;
    logic [PW-1:0]        mag;
    logic                 hit;
    logic                 fast;
    logic                 idle;
    logic [PW-1:0]        rate_ext;
    logic [TW-1:0]        det_delta;
    logic [TW-1:0]        move_delta;

    assign out_free     = !out_valid_reg || result.ready;
    assign fire         = in_valid_reg && out_free;
    assign sample.ready = !in_valid_reg || out_free;

    assign pins       = {in_a_reg, in_b_reg};
    assign dir        = qdd_pkg::decode_dir({prev_pins_reg, pins});
    assign sum        = (dir == qdd_pkg::DIR_CCW) ? partial_reg - PW'(1) : partial_reg + PW'(1);
    assign mag        = sum[PW-1] ? PW'(-sum) : PW'(sum);
    assign hit        = mag >= {1'b0, regs.counts_per_detent};
    assign det_delta  = in_now_reg - last_det_reg;
    assign move_delta = in_now_reg - last_move_reg;
    assign fast       = det_delta < {{(TW-qdd_pkg::MS_W){1'b0}}, regs.accel_threshold_ms};
    assign idle       = move_delta > {{(TW-qdd_pkg::MS_W){1'b0}}, regs.idle_timeout_ms};
    assign rate_ext   = (regs.accel_enable && fast) ? {1'b0, regs.accel_rate} : PW'(1);

    always_comb
    begin
        primed_next    = primed_reg;
        prev_pins_next = prev_pins_reg;
        partial_next   = partial_reg;
        last_move_next = last_move_reg;
        last_det_next  = last_det_reg;
        event_next     = 1'b0;
        step_next      = '0;

        if (!regs.decoder_enable)
        begin
            partial_next = '0;
        end
        else if (!primed_reg)
        begin
            primed_next    = 1'b1;
            prev_pins_next = pins;
            last_move_next = in_now_reg;
            partial_next   = '0;
        end
        else if (pins != prev_pins_reg)
        begin
            prev_pins_next = pins;
            if (dir != qdd_pkg::DIR_NONE)
            begin
                partial_next   = sum;
                last_move_next = in_now_reg;
                if (hit)
                begin
                    partial_next = '0;
                    event_next   = 1'b1;
                    // direction is positive only for a strictly positive count
                    step_next    = (!sum[PW-1] && (sum != '0)) ? rate_ext : -rate_ext;
                    if (regs.accel_enable)
                    begin
                        last_det_next = in_now_reg;
                    end
                end
            end
        end
        else if ((partial_reg != '0) && idle)
        begin
            partial_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            prev_pins_reg <= '0;
            partial_reg   <= '0;
            last_move_reg <= '0;
            last_det_reg  <= '0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                primed_reg    <= primed_next;
                prev_pins_reg <= prev_pins_next;
                last_move_reg <= last_move_next;
                last_det_reg  <= last_det_next;
            end
            if (regs.clear_pos)
            begin
                partial_reg <= '0;
            end
            else if (fire)
            begin
                partial_reg <= partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_a_reg   <= sample.pin_a;
            in_b_reg   <= sample.pin_b;
            in_now_reg <= sample.now_ms;
        end
        if (fire)
        begin
            out_event_reg <= event_next;
            out_step_reg  <= step_next;
            out_pos_reg   <= partial_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.detent_event = out_event_reg;
    assign result.detent_step  = out_step_reg;
    assign result.sub_position = out_pos_reg;

    a_event_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg) |-> (out_pos_reg == '0))
        else $error("detent word carries nonzero sub position");

    a_no_event_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_event_reg) |-> (out_step_reg == '0))
        else $error("nonzero step without detent");

    a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        regs.clear_pos |=> (partial_reg == '0))
        else $error("position not cleared on disable");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !regs.decoder_enable |-> (partial_reg == '0))
        else $error("position nonzero while disabled");

    a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (partial_reg == '0))
        else $error("position nonzero before first sample");

endmodule
`default_nettype wire

// File: rtl/core/quadrature_detent_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_unit
// Quadrature encoder decoder with detent counting, acceleration and idle
// clear.
// ----------------------------------------------------------------------------
// Each sample word (pin_a, pin_b, now_ms) yields exactly one result word
// (detent_event, detent_step, sub_position). One sample is taken every clock
// while the input register is empty or can move on; a word passes an input
// register and then a result register, from which its result is taken, and
// both registers keep moving while the result side accepts.
// Decode, accumulate and time compares sit in one stage between them.
// Register writes are always accepted; writing decoder_enable to 0 clears
// the partial position at once.
module quadrature_detent_decoder_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    qdd_sample_if.sink   sample,
    qdd_result_if.source result,
    qdd_cfg_if.sink      cfg
);

    qdd_pkg::cfg_t regs;

    qdd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    qdd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .sample (sample),
        .result (result)
    );

endmodule
`default_nettype wire

// File: dv/quadrature_detent_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_unit_tb
// Self-checking bench for the quadrature detent decoder. A short directed
// run covers priming, both directions, invalid jumps, the idle clear
// boundary, timestamp wrap, zero detent size, zero and full acceleration
// rate and the disabled decoder. Random quadrature walks with random
// timing follow under changing register settings. A tracker class predicts
// every result word and checks the output in order, while both handshake
// sides idle at random until the last phases, which run with no idling.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_unit_tb;
    import qdd_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic                    detent_event;
        logic signed [POS_W-1:0] detent_step;
        logic signed [POS_W-1:0] sub_position;
    } detent_word_t;

    class detent_tracker;
        logic [CNT_W-1:0]  counts_per_detent;
        logic              accel_enable;
        logic [CNT_W-1:0]  accel_rate;
        logic [MS_W-1:0]   accel_threshold_ms;
        logic [MS_W-1:0]   idle_timeout_ms;
        logic              decoder_enable;
        logic [1:0]        prev_pins;
        bit                primed;
        int                partial;
        logic [TIME_W-1:0] last_move_ms;
        logic [TIME_W-1:0] last_detent_ms;
        detent_word_t      pending_words[$];
        int                errors;

        function new();
            counts_per_detent  = RST_COUNTS_PER_DETENT;
            accel_enable       = RST_ACCEL_ENABLE;
            accel_rate         = RST_ACCEL_RATE;
            accel_threshold_ms = RST_ACCEL_THRESHOLD_MS;
            idle_timeout_ms    = RST_IDLE_TIMEOUT_MS;
            decoder_enable     = RST_DECODER_ENABLE;
            prev_pins          = 2'b00;
            primed             = 0;
            partial            = 0;
            last_move_ms       = '0;
            last_detent_ms     = '0;
            errors             = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COUNTS_PER_DETENT:  counts_per_detent = val[CNT_W-1:0];
                REG_ACCEL_ENABLE:       accel_enable = val[0];
                REG_ACCEL_RATE:         accel_rate = val[CNT_W-1:0];
                REG_ACCEL_THRESHOLD_MS: accel_threshold_ms = val[MS_W-1:0];
                REG_IDLE_TIMEOUT_MS:    idle_timeout_ms = val[MS_W-1:0];
                REG_DECODER_ENABLE:
                begin
                    decoder_enable = val[0];
                    if (!val[0])
                        partial = 0;
                end
                default: ;
            endcase
        endfunction

        // position on the 00-01-11-10 sequence; one step forward is clockwise
        function int turn(logic [1:0] from, logic [1:0] to);
            logic [1:0] d;
            d = {to[1], ^to} - {from[1], ^from};
            if (d == 2'd1)
                return 1;
            if (d == 2'd3)
                return -1;
            return 0;
        endfunction

        function void note_sample(logic a, logic b, logic [TIME_W-1:0] now);
            logic [1:0]        pins;
            logic [TIME_W-1:0] elapsed;
            detent_word_t      w;
            int                dir;
            int                mag;
            int                step;
            pins = {a, b};
            step = 0;
            w.detent_event = 1'b0;
            if (!decoder_enable)
                partial = 0;
            else if (!primed)
            begin
                primed = 1;
                prev_pins = pins;
                last_move_ms = now;
                partial = 0;
            end
            else if (pins != prev_pins)
            begin
                dir = turn(prev_pins, pins);
                if (dir != 0)
                begin
                    partial += dir;
                    last_move_ms = now;
                    mag = (partial < 0) ? -partial : partial;
                    if (mag >= int'(counts_per_detent))
                    begin
                        step = (partial > 0) ? 1 : -1;
                        partial = 0;
                        if (accel_enable)
                        begin
                            elapsed = now - last_detent_ms;
                            if (elapsed < {16'd0, accel_threshold_ms})
                                step = step * int'(accel_rate);
                            last_detent_ms = now;
                        end
                        w.detent_event = 1'b1;
                    end
                end
                prev_pins = pins;
            end
            else if (partial != 0)
            begin
                elapsed = now - last_move_ms;
                if (elapsed > {16'd0, idle_timeout_ms})
                    partial = 0;
            end
            w.detent_step  = step[POS_W-1:0];
            w.sub_position = partial[POS_W-1:0];
            pending_words.push_back(w);
        endfunction

        function void check_result(logic ev, logic [POS_W-1:0] step, logic [POS_W-1:0] sub);
            detent_word_t w;
            if (pending_words.size() == 0)
            begin
                $error("result word with no sample pending");
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (ev !== w.detent_event)
            begin
                $error("detent_event: expected %0d, got %0d", w.detent_event, ev);
                errors++;
            end
            if (step !== w.detent_step)
            begin
                $error("detent_step: expected %0d, got %0d",
                       $signed(w.detent_step), $signed(step));
                errors++;
            end
            if (sub !== w.sub_position)
            begin
                $error("sub_position: expected %0d, got %0d",
                       $signed(w.sub_position), $signed(sub));
                errors++;
            end
        endfunction

        function bit busy();
            return pending_words.size() != 0;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qdd_sample_if sample_ch();
    qdd_result_if result_ch();
    qdd_cfg_if    cfg_ch();

    quadrature_detent_decoder_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    detent_tracker     tracker = new();
    int                send_idle_pct;
    int                recv_stall_pct;
    int                stall_cycles;
    int                walk_pos;
    int                run_dir;
    int                run_left;
    logic [TIME_W-1:0] clock_ms;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.detent_event, result_ch.detent_step,
                                     result_ch.sub_position);
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_sample(input logic a, input logic b, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.pin_a  <= a;
        sample_ch.pin_b  <= b;
        sample_ch.now_ms <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        tracker.note_sample(a, b, now);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        while (tracker.busy())
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_setup(input int cpd, input int acc, input int rate,
                               input int thr, input int idle);
        settle();
        write_reg(REG_COUNTS_PER_DETENT, CFG_DATA_W'(cpd));
        write_reg(REG_ACCEL_ENABLE, CFG_DATA_W'(acc));
        write_reg(REG_ACCEL_RATE, CFG_DATA_W'(rate));
        write_reg(REG_ACCEL_THRESHOLD_MS, CFG_DATA_W'(thr));
        write_reg(REG_IDLE_TIMEOUT_MS, CFG_DATA_W'(idle));
        write_reg(REG_DECODER_ENABLE, 1);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly runs of quadrature steps, with holds, double-bit jumps and noise
    task automatic walk_sample();
        int         r;
        logic [1:0] p;
        if (run_left == 0)
        begin
            run_dir  = $urandom_range(0, 1) ? 1 : -1;
            run_left = $urandom_range(1, 2 * tracker.counts_per_detent + 4);
        end
        r = $urandom_range(0, 99);
        if (r < 78)
        begin
            walk_pos = (walk_pos + run_dir) & 3;
            run_left--;
        end
        else if (r >= 90 && r < 95)
            walk_pos = (walk_pos + 2) & 3;
        else if (r >= 95)
            walk_pos = $urandom_range(0, 3);
        p = walk_pos[1:0] ^ (walk_pos[1:0] >> 1);
        r = $urandom_range(0, 99);
        if (r < 60)
            clock_ms += $urandom_range(0, 20);
        else if (r < 85)
            clock_ms += $urandom_range(0, 200);
        else if (r < 95)
            clock_ms += $urandom_range(0, 1000);
        else if (r < 99)
            clock_ms += $urandom_range(0, 70000);
        else
            clock_ms = $urandom;
        push_sample(p[1], p[0], clock_ms);
    endtask

    initial
    begin
        int phase;
        int r;
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.pin_a  = 1'b0;
        sample_ch.pin_b  = 1'b0;
        sample_ch.now_ms = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_COUNTS_PER_DETENT;
        cfg_ch.data      = '0;
        send_idle_pct    = 34;
        recv_stall_pct   = 88;
        walk_pos         = 0;
        run_dir          = 1;
        run_left         = 0;
        clock_ms         = 32'd1000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: prime, clockwise detent, ccw count, invalid jump,
        // idle clear boundary, timestamp wrap, ccw detent
        push_sample(1'b0, 1'b0, 32'd0);
        push_sample(1'b0, 1'b1, 32'd10);
        push_sample(1'b1, 1'b1, 32'd20);
        push_sample(1'b1, 1'b0, 32'd30);
        push_sample(1'b0, 1'b0, 32'd40);
        push_sample(1'b1, 1'b0, 32'd50);
        push_sample(1'b0, 1'b1, 32'd60);
        push_sample(1'b0, 1'b1, 32'd550);
        push_sample(1'b0, 1'b1, 32'd551);
        push_sample(1'b1, 1'b1, 32'hFFFF_FFF0);
        push_sample(1'b1, 1'b1, 32'h0000_0100);
        push_sample(1'b1, 1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 1'b1, 32'd5);
        push_sample(1'b0, 1'b0, 32'd10);
        push_sample(1'b1, 1'b0, 32'd15);
        push_sample(1'b1, 1'b1, 32'd20);
        push_sample(1'b0, 1'b1, 32'd25);

        // every move a detent, fast detents scaled by zero
        settle();
        write_reg(REG_COUNTS_PER_DETENT, 0);
        write_reg(REG_ACCEL_ENABLE, 1);
        write_reg(REG_ACCEL_RATE, 0);
        write_reg(REG_ACCEL_THRESHOLD_MS, 16'hFFFF);
        write_reg(REG_IDLE_TIMEOUT_MS, 0);
        cfg_ch.valid <= 1'b0;
        push_sample(1'b0, 1'b0, 32'd100);
        push_sample(1'b0, 1'b1, 32'd101);

        // full rate
        settle();
        write_reg(REG_COUNTS_PER_DETENT, 1);
        write_reg(REG_ACCEL_RATE, 255);
        cfg_ch.valid <= 1'b0;
        push_sample(1'b1, 1'b1, 32'd200);
        push_sample(1'b0, 1'b1, 32'd300);

        // disabled decoder
        settle();
        write_reg(REG_DECODER_ENABLE, 0);
        cfg_ch.valid <= 1'b0;
        push_sample(1'b1, 1'b0, $urandom);
        push_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
        settle();
        write_reg(REG_DECODER_ENABLE, 1);
        cfg_ch.valid <= 1'b0;
        push_sample(1'b0, 1'b0, 32'd400);
        push_sample(1'b0, 1'b0, 32'd401);

        for (phase = 0; phase < 12; phase++)
        begin
            if (phase == 4)
            begin
                send_idle_pct  = 88;
                recv_stall_pct = 34;
            end
            if (phase == 8)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (phase == 1)
                apply_setup(255, 1, 255, 16'hFFFF, 16'hFFFF);
            else if (phase == 2)
                apply_setup(1, 1, 0, 0, 0);
            else
            begin
                r = $urandom_range(0, 9);
                apply_setup((r == 0) ? 0 : (r == 1) ? 255 : (r == 2) ? 1 : $urandom_range(2, 6),
                            $urandom_range(0, 1),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) * 255
                                                        : $urandom_range(0, 8),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) * 16'hFFFF
                                                        : $urandom_range(0, 300),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) * 16'hFFFF
                                                        : $urandom_range(0, 800));
            end
            repeat (125) walk_sample();
            if (phase == 6)
            begin
                settle();
                write_reg(REG_DECODER_ENABLE, 0);
                cfg_ch.valid <= 1'b0;
                repeat (20) walk_sample();
                settle();
                write_reg(REG_DECODER_ENABLE, 1);
                cfg_ch.valid <= 1'b0;
                repeat (20) walk_sample();
            end
        end

        settle();
        repeat (6) @(posedge clk);
        if (tracker.errors == 0 && !tracker.busy())
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
